>>> hdl/rudh_pkg.sv
package rudh_pkg;

	// Configuration register widths
	localparam int GAIN_W  = 24;
	localparam int CTR_W   = 12;
	localparam int SHIFT_W = 13;
	localparam int ROW_W   = 63;
	localparam int FLD_W   = 21;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 63;

	// Fixed point
	localparam int GAIN_FRAC = 40;   // radial gain scale 2^-40
	localparam int SPLIT_W   = 20;   // split of scale for the radial products
	localparam int NUM_SH    = 8;    // translation term alignment in numerators
	localparam int DEN_SH    = 10;   // constant term alignment in denominator
	localparam int FRAC_BITS = 12;   // quotient scale 2^12
	localparam int Q_W       = 17;   // quotient bits resolved by the divider
	localparam int OUT_W     = 16;

	localparam logic [Q_W-1:0] Q_POS_LIM = 17'd32767;
	localparam logic [Q_W-1:0] Q_NEG_LIM = 17'd32768;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_RADIAL_GAIN = 3'd0,
		REG_CENTRE_X    = 3'd1,
		REG_CENTRE_Y    = 3'd2,
		REG_SHIFT_X     = 3'd3,
		REG_SHIFT_Y     = 3'd4,
		REG_PROJ_ROW0   = 3'd5,
		REG_PROJ_ROW1   = 3'd6,
		REG_PROJ_ROW2   = 3'd7
	} reg_idx_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	// Reset values
	localparam logic [GAIN_W-1:0]         RST_GAIN     = 24'd648712;
	localparam logic [CTR_W-1:0]          RST_CENTRE_X = 12'd312;
	localparam logic [CTR_W-1:0]          RST_CENTRE_Y = 12'd462;
	localparam logic signed [SHIFT_W-1:0] RST_SHIFT_X  = -13'sd541;
	localparam logic signed [SHIFT_W-1:0] RST_SHIFT_Y  = -13'sd604;

endpackage

>>> hdl/rudh_if.sv
// Input point channel
interface rudh_pix_if #(parameter int COORD_BITS = 12) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pix_x;
	logic [COORD_BITS-1:0] pix_y;
	modport source (output valid, pix_x, pix_y, input ready);
	modport sink   (input valid, pix_x, pix_y, output ready);
endinterface

// Mapped point channel
interface rudh_map_if ();
	logic                                valid;
	logic                                ready;
	logic signed [rudh_pkg::OUT_W-1:0]   map_x;
	logic signed [rudh_pkg::OUT_W-1:0]   map_y;
	logic [1:0]                          status;
	modport source (output valid, map_x, map_y, status, input ready);
	modport sink   (input valid, map_x, map_y, status, output ready);
endinterface

// Register write channel
interface rudh_cfg_if ();
	logic                          valid;
	logic                          ready;
	logic [rudh_pkg::IDX_W-1:0]    index;
	logic [rudh_pkg::DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/radial_undistort_homography.sv
// Channel  Dir  Handshake     Payload
// in_pt    in   valid/ready   pix_x, pix_y (COORD_BITS each, unsigned)
// out_pt   out  valid/ready   map_x, map_y (16 signed), status (2)
// cfg      in   valid/ready   index (3), data (63); ready always high
//
// One point per cycle while the spare output entry is empty; an input beat passes through
// 11 arithmetic stages, 17 one-bit divider stages and the output register.
// Most of that depth is the restoring divider, one quotient bit per stage.
// arst_n clears valid bits, the output skid and the registers to defaults.
// All stages advance while the spare output entry is empty; a held result
// parks in the spare, so in_pt.ready is a flop and no beat is lost or repeated.
module radial_undistort_homography #(
	parameter int COORD_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	rudh_pix_if.sink   in_pt,
	rudh_map_if.source out_pt,
	rudh_cfg_if.sink   cfg
);

	localparam int MAXW  = (COORD_BITS > rudh_pkg::CTR_W) ? COORD_BITS : rudh_pkg::CTR_W;
	localparam int DW    = MAXW + 1;
	localparam int R2_W  = 2 * MAXW + 1;
	localparam int SC_W  = R2_W + rudh_pkg::GAIN_W + 1;
	localparam int A_W   = MAXW + SC_W - rudh_pkg::SPLIT_W;
	localparam int B_W   = MAXW + rudh_pkg::SPLIT_W;
	localparam int T_W   = rudh_pkg::GAIN_FRAC + 1;
	localparam int AH_W  = A_W - rudh_pkg::SPLIT_W;
	localparam int WH_W  = AH_W + 1;
	localparam int UX_W  = WH_W + 2;
	localparam int P_W   = UX_W + rudh_pkg::FLD_W;
	localparam int NUM_W = P_W + 2;
	localparam int R_W   = NUM_W + rudh_pkg::Q_W + 1;
	localparam int Q_W   = rudh_pkg::Q_W;
	localparam int NST   = 11 + Q_W;

	typedef struct packed {
		logic [R_W-1:0]   rx;
		logic [R_W-1:0]   ry;
		logic [NUM_W-1:0] d;
		logic [Q_W-1:0]   qx;
		logic [Q_W-1:0]   qy;
		logic             negx;
		logic             negy;
		logic             satx;
		logic             saty;
		logic             zero;
	} div_t;

	typedef struct packed {
		logic signed [rudh_pkg::OUT_W-1:0] map_x;
		logic signed [rudh_pkg::OUT_W-1:0] map_y;
		rudh_pkg::status_t                 status;
	} res_t;

	// ---------------- configuration registers ----------------
	logic [rudh_pkg::GAIN_W-1:0]         gain_q;
	logic [rudh_pkg::CTR_W-1:0]          cx_q, cy_q;
	logic signed [rudh_pkg::SHIFT_W-1:0] shx_q, shy_q;
	logic [rudh_pkg::ROW_W-1:0]          row0_q, row1_q, row2_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= rudh_pkg::RST_GAIN;
			cx_q   <= rudh_pkg::RST_CENTRE_X;
			cy_q   <= rudh_pkg::RST_CENTRE_Y;
			shx_q  <= rudh_pkg::RST_SHIFT_X;
			shy_q  <= rudh_pkg::RST_SHIFT_Y;
			row0_q <= '0;
			row1_q <= '0;
			row2_q <= '0;
		end else if (cfg.valid) begin
			case (rudh_pkg::reg_idx_t'(cfg.index))
				rudh_pkg::REG_RADIAL_GAIN: gain_q <= cfg.data[rudh_pkg::GAIN_W-1:0];
				rudh_pkg::REG_CENTRE_X:    cx_q   <= cfg.data[rudh_pkg::CTR_W-1:0];
				rudh_pkg::REG_CENTRE_Y:    cy_q   <= cfg.data[rudh_pkg::CTR_W-1:0];
				rudh_pkg::REG_SHIFT_X:     shx_q  <= cfg.data[rudh_pkg::SHIFT_W-1:0];
				rudh_pkg::REG_SHIFT_Y:     shy_q  <= cfg.data[rudh_pkg::SHIFT_W-1:0];
				rudh_pkg::REG_PROJ_ROW0:   row0_q <= cfg.data[rudh_pkg::ROW_W-1:0];
				rudh_pkg::REG_PROJ_ROW1:   row1_q <= cfg.data[rudh_pkg::ROW_W-1:0];
				rudh_pkg::REG_PROJ_ROW2:   row2_q <= cfg.data[rudh_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// matrix fields
	logic signed [rudh_pkg::FLD_W-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
	assign h00 = row0_q[20:0];
	assign h01 = row0_q[41:21];
	assign h02 = row0_q[62:42];
	assign h10 = row1_q[20:0];
	assign h11 = row1_q[41:21];
	assign h12 = row1_q[62:42];
	assign h20 = row2_q[20:0];
	assign h21 = row2_q[41:21];
	assign h22 = row2_q[62:42];

	// ---------------- pipeline control ----------------
	logic           adv;
	logic [NST-1:0] vld_q;
	logic           sv_q;   // spare output entry occupied
	logic           ov_q;   // output register occupied

	assign adv         = !sv_q;
	assign in_pt.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_pt.valid};
		end
	end

	// ---------------- s1: centre offsets ----------------
	logic signed [DW-1:0] dx_s1, dy_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DW'(signed'({1'b0, in_pt.pix_x})) - DW'(signed'({1'b0, cx_q}));
			dy_s1 <= DW'(signed'({1'b0, in_pt.pix_y})) - DW'(signed'({1'b0, cy_q}));
		end
	end

	// ---------------- s2: squared radius ----------------
	logic signed [2*DW-1:0] sqx, sqy;
	logic [R2_W-1:0]        r2_s2;
	logic signed [DW-1:0]   dx_s2, dy_s2;
	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			r2_s2 <= R2_W'(sqx) + R2_W'(sqy);
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
		end
	end

	// ---------------- s3: scale = 2^40 + k*r2 ----------------
	logic [rudh_pkg::GAIN_W+R2_W-1:0] gp;
	logic [SC_W-1:0]                  scale_s3;
	logic signed [DW-1:0]             dx_s3, dy_s3;
	assign gp = gain_q * r2_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			scale_s3 <= SC_W'(gp) + (SC_W'(1) << rudh_pkg::GAIN_FRAC);
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
		end
	end

	// ---------------- s4: |d| * scale, split in two products ----------------
	logic [MAXW-1:0] mx, my;
	logic [A_W-1:0]  ax_s4, ay_s4;
	logic [B_W-1:0]  bx_s4, by_s4;
	logic            nx_s4, ny_s4;
	assign mx = MAXW'(dx_s3[DW-1] ? -dx_s3 : dx_s3);
	assign my = MAXW'(dy_s3[DW-1] ? -dy_s3 : dy_s3);
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s4 <= mx * scale_s3[SC_W-1:rudh_pkg::SPLIT_W];
			bx_s4 <= mx * scale_s3[rudh_pkg::SPLIT_W-1:0];
			ay_s4 <= my * scale_s3[SC_W-1:rudh_pkg::SPLIT_W];
			by_s4 <= my * scale_s3[rudh_pkg::SPLIT_W-1:0];
			nx_s4 <= dx_s3[DW-1];
			ny_s4 <= dy_s3[DW-1];
		end
	end

	// ---------------- s5: recombine low parts ----------------
	logic [AH_W-1:0] ahx_s5, ahy_s5;
	logic [T_W-1:0]  tx_s5, ty_s5;
	logic            nx_s5, ny_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			ahx_s5 <= ax_s4[A_W-1:rudh_pkg::SPLIT_W];
			ahy_s5 <= ay_s4[A_W-1:rudh_pkg::SPLIT_W];
			tx_s5  <= T_W'({ax_s4[rudh_pkg::SPLIT_W-1:0], {rudh_pkg::SPLIT_W{1'b0}}})
				+ T_W'(bx_s4);
			ty_s5  <= T_W'({ay_s4[rudh_pkg::SPLIT_W-1:0], {rudh_pkg::SPLIT_W{1'b0}}})
				+ T_W'(by_s4);
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
		end
	end

	// ---------------- s6: integer part and sticky fraction ----------------
	logic [WH_W-1:0] wx_s6, wy_s6;
	logic            fx_s6, fy_s6, nx_s6, ny_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s6 <= WH_W'(ahx_s5) + WH_W'(tx_s5[T_W-1:rudh_pkg::GAIN_FRAC]);
			wy_s6 <= WH_W'(ahy_s5) + WH_W'(ty_s5[T_W-1:rudh_pkg::GAIN_FRAC]);
			fx_s6 <= |tx_s5[rudh_pkg::GAIN_FRAC-1:0];
			fy_s6 <= |ty_s5[rudh_pkg::GAIN_FRAC-1:0];
			nx_s6 <= nx_s5;
			ny_s6 <= ny_s5;
		end
	end

	// ---------------- s7: undistorted point, axes swapped, minus shift ----------------
	localparam logic signed [UX_W-1:0] U_ZERO = '0;
	localparam logic signed [UX_W-1:0] U_ONE  = UX_W'(1);
	logic signed [UX_W-1:0] cxe, cye, wxe, wye, basex, basey, corx, cory;
	logic signed [UX_W-1:0] ux_s7, uy_s7;
	assign cxe   = UX_W'(signed'({1'b0, cx_q}));
	assign cye   = UX_W'(signed'({1'b0, cy_q}));
	assign wxe   = UX_W'(signed'({1'b0, wx_s6}));
	assign wye   = UX_W'(signed'({1'b0, wy_s6}));
	assign basex = cxe - wxe;
	assign basey = cye - wye;
	// negative offset: truncate toward zero, so step down only while still positive
	assign corx  = !nx_s6 ? (cxe + wxe)
		: ((fx_s6 && basex > U_ZERO) ? basex - U_ONE : basex);
	assign cory  = !ny_s6 ? (cye + wye)
		: ((fy_s6 && basey > U_ZERO) ? basey - U_ONE : basey);
	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s7 <= cory - UX_W'(shx_q);
			uy_s7 <= corx - UX_W'(shy_q);
		end
	end

	// ---------------- s8: matrix products ----------------
	logic signed [P_W-1:0] p00_s8, p01_s8, p10_s8, p11_s8, p20_s8, p21_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			p00_s8 <= ux_s7 * h00;
			p01_s8 <= uy_s7 * h01;
			p10_s8 <= ux_s7 * h10;
			p11_s8 <= uy_s7 * h11;
			p20_s8 <= ux_s7 * h20;
			p21_s8 <= uy_s7 * h21;
		end
	end

	// ---------------- s9: numerators and denominator ----------------
	logic signed [NUM_W-1:0] numx_s9, numy_s9, den_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			numx_s9 <= NUM_W'(p00_s8) + NUM_W'(p01_s8) + (NUM_W'(h02) <<< rudh_pkg::NUM_SH);
			numy_s9 <= NUM_W'(p10_s8) + NUM_W'(p11_s8) + (NUM_W'(h12) <<< rudh_pkg::NUM_SH);
			den_s9  <= NUM_W'(p20_s8) + NUM_W'(p21_s8) + (NUM_W'(h22) <<< rudh_pkg::DEN_SH);
		end
	end

	// ---------------- s10: magnitudes and signs ----------------
	logic [NUM_W-1:0] mnx_s10, mny_s10, md_s10;
	logic             negx_s10, negy_s10, zero_s10;
	always_ff @(posedge clk) begin
		if (adv) begin
			mnx_s10  <= NUM_W'(numx_s9[NUM_W-1] ? -numx_s9 : numx_s9);
			mny_s10  <= NUM_W'(numy_s9[NUM_W-1] ? -numy_s9 : numy_s9);
			md_s10   <= NUM_W'(den_s9[NUM_W-1] ? -den_s9 : den_s9);
			negx_s10 <= numx_s9[NUM_W-1] ^ den_s9[NUM_W-1];
			negy_s10 <= numy_s9[NUM_W-1] ^ den_s9[NUM_W-1];
			zero_s10 <= (den_s9 == '0);
		end
	end

	// ---------------- s11: scaled dividends, overflow screen ----------------
	logic [R_W-1:0] nxs, nys, dtop;
	div_t           div_s [Q_W+1];
	assign nxs  = R_W'(mnx_s10) << rudh_pkg::FRAC_BITS;
	assign nys  = R_W'(mny_s10) << rudh_pkg::FRAC_BITS;
	assign dtop = R_W'(md_s10) << Q_W;
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].rx   <= nxs;
			div_s[0].ry   <= nys;
			div_s[0].d    <= md_s10;
			div_s[0].qx   <= '0;
			div_s[0].qy   <= '0;
			div_s[0].negx <= negx_s10;
			div_s[0].negy <= negy_s10;
			div_s[0].satx <= (nxs >= dtop);
			div_s[0].saty <= (nys >= dtop);
			div_s[0].zero <= zero_s10;
		end
	end

	// ---------------- divider: one quotient bit per stage, MSB first ----------------
	for (genvar i = 0; i < Q_W; i++) begin : g_div
		localparam int J = Q_W - 1 - i;
		logic [R_W-1:0] dsh;
		logic           gex, gey;
		div_t           nxt;
		assign dsh = R_W'(div_s[i].d) << J;
		assign gex = (div_s[i].rx >= dsh);
		assign gey = (div_s[i].ry >= dsh);
		always_comb begin
			nxt       = div_s[i];
			nxt.rx    = gex ? div_s[i].rx - dsh : div_s[i].rx;
			nxt.ry    = gey ? div_s[i].ry - dsh : div_s[i].ry;
			nxt.qx[J] = gex;
			nxt.qy[J] = gey;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[i+1] <= nxt;
			end
		end
	end

	// ---------------- sign, saturation, status ----------------
	div_t dl;
	res_t res;
	logic sx, sy;
	assign dl = div_s[Q_W];
	assign sx = dl.satx || (dl.negx ? (dl.qx > rudh_pkg::Q_NEG_LIM) : (dl.qx > rudh_pkg::Q_POS_LIM));
	assign sy = dl.saty || (dl.negy ? (dl.qy > rudh_pkg::Q_NEG_LIM) : (dl.qy > rudh_pkg::Q_POS_LIM));
	always_comb begin
		if (dl.zero) begin
			res.map_x  = '0;
			res.map_y  = '0;
			res.status = rudh_pkg::ST_ZERO_DEN;
		end else begin
			if (sx)
				res.map_x = dl.negx ? rudh_pkg::OUT_MIN : rudh_pkg::OUT_MAX;
			else
				res.map_x = dl.negx ? rudh_pkg::OUT_W'(Q_W'(0) - dl.qx)
					: rudh_pkg::OUT_W'(dl.qx);
			if (sy)
				res.map_y = dl.negy ? rudh_pkg::OUT_MIN : rudh_pkg::OUT_MAX;
			else
				res.map_y = dl.negy ? rudh_pkg::OUT_W'(Q_W'(0) - dl.qy)
					: rudh_pkg::OUT_W'(dl.qy);
			res.status = (sx || sy) ? rudh_pkg::ST_SAT : rudh_pkg::ST_OK;
		end
	end

	// ---------------- output register with spare entry ----------------
	res_t out_q, spare_q;
	logic inc, take;
	assign inc  = adv && vld_q[NST-1];
	assign take = ov_q && out_pt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (!ov_q || take) begin
			ov_q <= sv_q || inc;
			sv_q <= 1'b0;
		end else if (inc) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || take) begin
			out_q <= sv_q ? spare_q : res;
		end else if (inc) begin
			spare_q <= res;
		end
	end

	assign out_pt.valid  = ov_q;
	assign out_pt.map_x  = out_q.map_x;
	assign out_pt.map_y  = out_q.map_y;
	assign out_pt.status = out_q.status;

	// ---------------- assertions ----------------
	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("spare entry holds a beat while output register is empty");

	a_spare_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sv_q) |-> $past(ov_q && !out_pt.ready && vld_q[NST-1]))
		else $error("spare entry filled without a held output");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_q.status == rudh_pkg::ST_SAT) |->
		(out_q.map_x == rudh_pkg::OUT_MAX || out_q.map_x == rudh_pkg::OUT_MIN ||
		 out_q.map_y == rudh_pkg::OUT_MAX || out_q.map_y == rudh_pkg::OUT_MIN))
		else $error("saturated status without a saturated coordinate");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_q.status == rudh_pkg::ST_ZERO_DEN) |->
		(out_q.map_x == '0 && out_q.map_y == '0))
		else $error("zero denominator result carries a nonzero point");

endmodule

>>> tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB      = 12;
	localparam int PIPE_LAT = 29;

	// One expected mapped point
	typedef struct {
		logic signed [rudh_pkg::OUT_W-1:0] mx;
		logic signed [rudh_pkg::OUT_W-1:0] my;
		rudh_pkg::status_t                 st;
	} map_pt_t;

	// Predicts mapped points from a private copy of the registers and checks results
	class map_board;
		logic [rudh_pkg::GAIN_W-1:0]         gain;
		logic [rudh_pkg::CTR_W-1:0]          cx, cy;
		logic signed [rudh_pkg::SHIFT_W-1:0] sx, sy;
		logic [rudh_pkg::ROW_W-1:0]          rows [3];
		map_pt_t                             pend [$];
		int                                  errs;
		int                                  n_ok, n_zero, n_sat;

		function void defaults();
			gain = rudh_pkg::RST_GAIN;
			cx = rudh_pkg::RST_CENTRE_X;
			cy = rudh_pkg::RST_CENTRE_Y;
			sx = rudh_pkg::RST_SHIFT_X;
			sy = rudh_pkg::RST_SHIFT_Y;
			for (int i = 0; i < 3; i++)
				rows[i] = '0;
		endfunction

		function void set_reg(rudh_pkg::reg_idx_t idx, logic [rudh_pkg::DATA_W-1:0] v);
			case (idx)
				rudh_pkg::REG_RADIAL_GAIN: gain = v[rudh_pkg::GAIN_W-1:0];
				rudh_pkg::REG_CENTRE_X:    cx = v[rudh_pkg::CTR_W-1:0];
				rudh_pkg::REG_CENTRE_Y:    cy = v[rudh_pkg::CTR_W-1:0];
				rudh_pkg::REG_SHIFT_X:     sx = v[rudh_pkg::SHIFT_W-1:0];
				rudh_pkg::REG_SHIFT_Y:     sy = v[rudh_pkg::SHIFT_W-1:0];
				rudh_pkg::REG_PROJ_ROW0:   rows[0] = v[rudh_pkg::ROW_W-1:0];
				rudh_pkg::REG_PROJ_ROW1:   rows[1] = v[rudh_pkg::ROW_W-1:0];
				rudh_pkg::REG_PROJ_ROW2:   rows[2] = v[rudh_pkg::ROW_W-1:0];
				default: ;
			endcase
		endfunction

		function longint coef(int r, int i);
			logic [rudh_pkg::FLD_W-1:0] f;
			f = rows[r][rudh_pkg::FLD_W*i +: rudh_pkg::FLD_W];
			return longint'($signed(f));
		endfunction

		// trunc(c + d*scale/2^40) toward zero, with the low-side rounding of the block
		function longint undistort(longint c, longint d, logic [63:0] scale);
			logic [127:0] p;
			longint       whole, base;
			p = 128'(d < 0 ? -d : d) * 128'(scale);
			whole = longint'(p >> rudh_pkg::GAIN_FRAC);
			if (d >= 0)
				return c + whole;
			base = c - whole;
			if (p[rudh_pkg::GAIN_FRAC-1:0] != 0 && base - 1 >= 0)
				return base - 1;
			return base;
		endfunction

		// trunc(num*2^12/den), saturated to 16 bits
		function logic signed [rudh_pkg::OUT_W-1:0] divide(longint num, longint den,
				ref bit sat);
			logic [127:0] n, d, q;
			bit           neg;
			neg = (num < 0) != (den < 0);
			n = 128'(num < 0 ? -num : num);
			d = 128'(den < 0 ? -den : den);
			q = (n << rudh_pkg::FRAC_BITS) / d;
			if (neg) begin
				if (q > 32768) begin
					sat = 1;
					return rudh_pkg::OUT_MIN;
				end
				return rudh_pkg::OUT_W'(-longint'(q));
			end
			if (q > 32767) begin
				sat = 1;
				return rudh_pkg::OUT_MAX;
			end
			return rudh_pkg::OUT_W'(q);
		endfunction

		function void note(logic [CB-1:0] px, logic [CB-1:0] py);
			longint      dx, dy, ux, uy, nx, ny, den;
			logic [63:0] r2, scale;
			map_pt_t     e;
			bit          sat;
			dx = longint'(px) - longint'(cx);
			dy = longint'(py) - longint'(cy);
			r2 = 64'(dx * dx + dy * dy);
			scale = (64'd1 << rudh_pkg::GAIN_FRAC) + 64'(gain) * r2;
			// axes swap here
			ux = undistort(longint'(cy), dy, scale) - longint'(sx);
			uy = undistort(longint'(cx), dx, scale) - longint'(sy);
			nx = ux * coef(0, 0) + uy * coef(0, 1) + coef(0, 2) * (1 << rudh_pkg::NUM_SH);
			ny = ux * coef(1, 0) + uy * coef(1, 1) + coef(1, 2) * (1 << rudh_pkg::NUM_SH);
			den = ux * coef(2, 0) + uy * coef(2, 1) + coef(2, 2) * (1 << rudh_pkg::DEN_SH);
			sat = 0;
			e.mx = '0;
			e.my = '0;
			if (den == 0) begin
				e.st = rudh_pkg::ST_ZERO_DEN;
			end else begin
				e.mx = divide(nx, den, sat);
				e.my = divide(ny, den, sat);
				e.st = sat ? rudh_pkg::ST_SAT : rudh_pkg::ST_OK;
			end
			pend.push_back(e);
		endfunction

		function void check(logic signed [rudh_pkg::OUT_W-1:0] mx,
				logic signed [rudh_pkg::OUT_W-1:0] my, logic [1:0] st);
			map_pt_t e;
			if (pend.size() == 0) begin
				$error("unexpected mapped point x=%0d y=%0d status=%0d", mx, my, st);
				errs++;
				return;
			end
			e = pend.pop_front();
			case (e.st)
				rudh_pkg::ST_OK:       n_ok++;
				rudh_pkg::ST_ZERO_DEN: n_zero++;
				default:               n_sat++;
			endcase
			if (mx !== e.mx) begin
				$error("map_x expected %0d got %0d", e.mx, mx);
				errs++;
			end
			if (my !== e.my) begin
				$error("map_y expected %0d got %0d", e.my, my);
				errs++;
			end
			if (st !== e.st) begin
				$error("status expected %0d got %0d", e.st, st);
				errs++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rudh_pix_if #(.COORD_BITS(CB)) pix ();
	rudh_map_if mp ();
	rudh_cfg_if cf ();

	radial_undistort_homography #(.COORD_BITS(CB)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_pt  (pix),
		.out_pt (mp),
		.cfg    (cf)
	);

	map_board board;
	bit       gaps_on;
	int       long_hold;
	int       sent;

	// Clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("radial_undistort_homography: mismatch");
		$finish;
	end

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int hold;
		hold = 0;
		mp.ready = 0;
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				hold = long_hold;
				long_hold = 0;
			end else if (hold == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 7);
			end
			if (hold > 0) begin
				hold--;
				mp.ready <= 0;
			end else begin
				mp.ready <= 1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && mp.valid && mp.ready)
			board.check(mp.map_x, mp.map_y, mp.status);

	// Register write; leaves valid high, caller lowers it
	task automatic cfg_write(rudh_pkg::reg_idx_t idx, logic [rudh_pkg::DATA_W-1:0] v);
		cf.valid <= 1;
		cf.index <= idx;
		cf.data <= v;
		do @(posedge clk); while (!cf.ready);
		board.set_reg(idx, v);
		@(negedge clk);
	endtask

	// Point beat; leaves valid high, or low after a random gap; caller lowers it
	task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y);
		pix.valid <= 1;
		pix.pix_x <= x;
		pix.pix_y <= y;
		do @(posedge clk); while (!pix.ready);
		board.note(x, y);
		sent++;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			pix.valid <= 0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	task automatic drain();
		pix.valid <= 0;
		while (board.pend.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 5) @(negedge clk);
	endtask

	function automatic logic [rudh_pkg::ROW_W-1:0] row(int a, int b, int c);
		return {rudh_pkg::FLD_W'(c), rudh_pkg::FLD_W'(b), rudh_pkg::FLD_W'(a)};
	endfunction

	function automatic int rand_fld();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 1048575 - $urandom_range(0, 3) * 0 : -1048576;
			1: return int'($urandom_range(0, 2000)) - 1000;
			default: return int'($urandom_range(0, 2097151)) - 1048576;
		endcase
	endfunction

	task automatic camera_rows(int jitter);
		int j [9];
		foreach (j[i])
			j[i] = jitter ? int'($urandom_range(0, 2 * jitter)) - jitter : 0;
		cfg_write(rudh_pkg::REG_PROJ_ROW0, row(-22186 + j[0], -91752 + j[1], 211106 + j[2]));
		cfg_write(rudh_pkg::REG_PROJ_ROW1, row(2792 + j[3], -124238 + j[4], 289858 + j[5]));
		cfg_write(rudh_pkg::REG_PROJ_ROW2, row(25854 + j[6], -629283 + j[7], 262144 + j[8]));
	endtask

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	// Main sequence
	initial begin
		int n;
		board = new();
		board.defaults();
		gaps_on = 1;
		long_hold = 0;
		sent = 0;
		pix.valid = 0;
		pix.pix_x = '0;
		pix.pix_y = '0;
		cf.valid = 0;
		cf.index = rudh_pkg::REG_RADIAL_GAIN;
		cf.data = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Reset registers: zero matrix gives zero denominator
		send_point(0, 0);
		send_point(4095, 4095);
		send_point(312, 462);
		for (int i = 0; i < 20; i++)
			send_point(rand_coord(), rand_coord());
		drain();

		// Camera matrix: corners, centre, field extremes
		camera_rows(0);
		cf.valid <= 0;
		@(negedge clk);
		send_point(0, 0);
		send_point(4095, 0);
		send_point(0, 4095);
		send_point(4095, 4095);
		send_point(312, 462);
		send_point(313, 461);
		send_point(2048, 2048);
		send_point(12'hAAA, 12'h555);
		send_point(12'h555, 12'hAAA);
		for (int i = 0; i < 400; i++) begin
			if (i == 100)
				long_hold = 300;
			if (i == 250)
				drain();
			send_point(rand_coord(), rand_coord());
		end
		drain();

		// Register extremes and random settings
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin
					cfg_write(rudh_pkg::REG_RADIAL_GAIN, 24'hFFFFFF);
					cfg_write(rudh_pkg::REG_CENTRE_X, 0);
					cfg_write(rudh_pkg::REG_CENTRE_Y, 0);
					cfg_write(rudh_pkg::REG_SHIFT_X, 13'h0FFF);
					cfg_write(rudh_pkg::REG_SHIFT_Y, 13'h1000);
				end
				1: begin
					cfg_write(rudh_pkg::REG_RADIAL_GAIN, 0);
					cfg_write(rudh_pkg::REG_CENTRE_X, 4095);
					cfg_write(rudh_pkg::REG_CENTRE_Y, 4095);
					cfg_write(rudh_pkg::REG_SHIFT_X, 13'h1000);
					cfg_write(rudh_pkg::REG_SHIFT_Y, 13'h0FFF);
				end
				default: begin
					cfg_write(rudh_pkg::REG_RADIAL_GAIN, $urandom_range(0, 3) == 0 ?
						$urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 2000000));
					cfg_write(rudh_pkg::REG_CENTRE_X, $urandom_range(0, 4095));
					cfg_write(rudh_pkg::REG_CENTRE_Y, $urandom_range(0, 4095));
					cfg_write(rudh_pkg::REG_SHIFT_X, $urandom_range(0, 8191));
					cfg_write(rudh_pkg::REG_SHIFT_Y, $urandom_range(0, 8191));
					case ($urandom_range(0, 3))
						0: begin
							cfg_write(rudh_pkg::REG_PROJ_ROW0,
								row(rand_fld(), rand_fld(), rand_fld()));
							cfg_write(rudh_pkg::REG_PROJ_ROW1,
								row(rand_fld(), rand_fld(), rand_fld()));
							cfg_write(rudh_pkg::REG_PROJ_ROW2,
								row(rand_fld(), rand_fld(), rand_fld()));
						end
						1: begin
							camera_rows(0);
							cfg_write(rudh_pkg::REG_PROJ_ROW2,
								row(0, 0, $urandom_range(0, 1)));
						end
						default: camera_rows(2000);
					endcase
				end
			endcase
			cf.valid <= 0;
			@(negedge clk);
			if (ph == 9)
				gaps_on = 0;
			n = (ph < 2) ? 100 : 135;
			for (int i = 0; i < n; i++)
				send_point(rand_coord(), rand_coord());
			drain();
		end

		// Settle
		repeat (PIPE_LAT * 2) @(negedge clk);
		$display("Sent %0d points over 12 register settings, incl. extremes and zero matrix.",
			sent);
		$display("Results: %0d ok, %0d zero denominator, %0d saturated.",
			board.n_ok, board.n_zero, board.n_sat);
		if (board.errs == 0 && board.pend.size() == 0) begin
			$display("radial_undistort_homography: match");
		end else begin
			$display("radial_undistort_homography: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/rudh_pkg.sv
hdl/rudh_if.sv
hdl/radial_undistort_homography.sv
tb/sv/tb.sv
